// ===== rtl/mavg_pkg.sv =====
// Shared types and constants for the five-channel boxcar averager.
// Holds window lengths, reciprocal constants for the divide and the result word layout.
// No dependencies.
package mavg_pkg;

    localparam int NUM_CH   = 5;
    localparam int TAG_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;

    localparam int WINDOW_A = 151;
    localparam int WINDOW_B = 189;
    localparam int WINDOW_C = 11;
    localparam int WINDOW_D = 7;
    localparam int WINDOW_E = 13;

    localparam int WINDOW [NUM_CH] = '{WINDOW_A, WINDOW_B, WINDOW_C, WINDOW_D, WINDOW_E};

    // Divide by multiply: q = (|sum| * RECIP) >> RSHIFT, exact for |sum| < 2**SUM_W.
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int QUO_W   = SAMPLE_W + 1;

    localparam int RSHIFT [NUM_CH] = '{
        SUM_W + $clog2(WINDOW_A),
        SUM_W + $clog2(WINDOW_B),
        SUM_W + $clog2(WINDOW_C),
        SUM_W + $clog2(WINDOW_D),
        SUM_W + $clog2(WINDOW_E)
    };

    localparam logic [RECIP_W-1:0] RECIP [NUM_CH] = '{
        RECIP_W'(((64'd1 << RSHIFT[0]) + 64'(WINDOW_A) - 64'd1) / 64'(WINDOW_A)),
        RECIP_W'(((64'd1 << RSHIFT[1]) + 64'(WINDOW_B) - 64'd1) / 64'(WINDOW_B)),
        RECIP_W'(((64'd1 << RSHIFT[2]) + 64'(WINDOW_C) - 64'd1) / 64'(WINDOW_C)),
        RECIP_W'(((64'd1 << RSHIFT[3]) + 64'(WINDOW_D) - 64'd1) / 64'(WINDOW_D)),
        RECIP_W'(((64'd1 << RSHIFT[4]) + 64'(WINDOW_E) - 64'd1) / 64'(WINDOW_E))
    };

    // Output queue: depth must be a power of two.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [TAG_W-1:0]    t_tag;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

    typedef t_sample t_sample_arr [NUM_CH];
    typedef t_sum    t_sum_arr    [NUM_CH];

    typedef struct packed {
        logic vld;
        t_tag tag;
    } t_stage;

    typedef struct packed {
        t_tag    tag_out;
        t_sample avg_a;
        t_sample avg_b;
        t_sample avg_c;
        t_sample avg_d;
        t_sample avg_e;
    } t_result;

endpackage

// ===== rtl/mavg_if.sv =====
// Valid/ready channel interfaces for the averager input and output words.
// Depends on mavg_pkg.
interface mavg_in_if;
    import mavg_pkg::*;

    logic    valid;
    logic    ready;
    t_tag    tag;
    t_sample sample_a;
    t_sample sample_b;
    t_sample sample_c;
    t_sample sample_d;
    t_sample sample_e;

    modport source (
        output valid, tag, sample_a, sample_b, sample_c, sample_d, sample_e,
        input  ready
    );
    modport sink (
        input  valid, tag, sample_a, sample_b, sample_c, sample_d, sample_e,
        output ready
    );
endinterface

interface mavg_out_if;
    import mavg_pkg::*;

    logic    valid;
    logic    ready;
    t_tag    tag_out;
    t_sample avg_a;
    t_sample avg_b;
    t_sample avg_c;
    t_sample avg_d;
    t_sample avg_e;

    modport source (
        output valid, tag_out, avg_a, avg_b, avg_c, avg_d, avg_e,
        input  ready
    );
    modport sink (
        input  valid, tag_out, avg_a, avg_b, avg_c, avg_d, avg_e,
        output ready
    );
endinterface

// ===== rtl/mavg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents. No dependencies.
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/mavg_bank.sv =====
// Per-channel ring RAMs, write pointers, fill flags and running sums.
// Depends on mavg_pkg and mavg_ram.
module mavg_bank (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  mavg_pkg::t_sample_arr i_sample,
    input  logic                  i_upd,
    output mavg_pkg::t_sum_arr    o_sum
);
    import mavg_pkg::*;

    for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
        localparam int W  = WINDOW[g];
        localparam int AW = (W > 1) ? $clog2(W) : 1;

        logic [AW-1:0]       r_ptr;
        logic                r_full;
        logic                r_full_q;
        t_sample             r_samp_q;
        t_sum                r_sum;
        t_sum                n_sum;
        logic [SAMPLE_W-1:0] w_rdata;
        logic [SAMPLE_W-1:0] w_old;
        logic                w_last;

        assign w_last = (r_ptr == AW'(W - 1));

        // Oldest sample and new sample swap places in one RAM access.
        mavg_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (W)
        ) u_ring (
            .i_clk   (i_clk),
            .i_we    (i_wr),
            .i_waddr (r_ptr),
            .i_wdata (i_sample[g]),
            .i_re    (i_wr),
            .i_raddr (r_ptr),
            .o_rdata (w_rdata)
        );

        // Entries not yet written in the first lap read as zero.
        assign w_old = r_full_q ? w_rdata : '0;

        always_comb begin
            n_sum = r_sum - t_sum'($signed(w_old)) + t_sum'(r_samp_q);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ptr  <= '0;
                r_full <= 1'b0;
                r_sum  <= '0;
            end else begin
                if (i_wr) begin
                    r_ptr <= w_last ? '0 : r_ptr + 1'b1;
                    if (w_last) begin
                        r_full <= 1'b1;
                    end
                end
                if (i_upd) begin
                    r_sum <= n_sum;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_wr) begin
                r_samp_q <= i_sample[g];
                r_full_q <= r_full;
            end
        end

        assign o_sum[g] = r_sum;
    end
endmodule

// ===== rtl/mavg_scale.sv =====
// Divide each running sum by its window length, truncating toward zero.
// Reciprocal multiply in one stage, shift and sign restore after it. Depends on mavg_pkg.
module mavg_scale (
    input  logic                  i_clk,
    input  mavg_pkg::t_sum_arr    i_sum,
    output mavg_pkg::t_sample_arr o_avg
);
    import mavg_pkg::*;

    for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
        logic [SUM_W-1:0]  w_mag;
        logic [PROD_W-1:0] r_prod;
        logic              r_neg;
        logic [QUO_W-1:0]  w_quo;

        assign w_mag = i_sum[g][SUM_W-1] ? SUM_W'(-i_sum[g]) : SUM_W'(i_sum[g]);

        always_ff @(posedge i_clk) begin
            r_prod <= PROD_W'(w_mag) * PROD_W'(RECIP[g]);
            r_neg  <= i_sum[g][SUM_W-1];
        end

        assign w_quo    = QUO_W'(r_prod >> RSHIFT[g]);
        assign o_avg[g] = r_neg ? SAMPLE_W'(-w_quo) : SAMPLE_W'(w_quo);
    end
endmodule

// ===== rtl/mavg_fifo.sv =====
// Result queue in flip-flops; parts the pipeline from the output handshake.
// Depends on mavg_pkg.
module mavg_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  mavg_pkg::t_result       i_wdata,
    input  logic                    i_pop,
    output mavg_pkg::t_result       o_rdata,
    output logic                    o_valid,
    output logic [mavg_pkg::CNT_W-1:0] o_count
);
    import mavg_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;
endmodule

// ===== rtl/five_channel_moving_average.sv =====
// Five-channel boxcar moving average. An accepted word passes the sum update, the multiply
// register and the queue write before it reaches the output head. Throughput: one word per
// cycle while the queue has room, set by the single read-modify-write of each ring RAM and
// running-sum register per word. Reset: pointers, sums and fill flags clear at once; ring
// RAMs are not swept, unwritten entries read as zero until the first lap completes.
// Depends on mavg_pkg, mavg_if, mavg_ram, mavg_bank, mavg_scale and mavg_fifo.
module five_channel_moving_average (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mavg_in_if.sink    i_in,
    mavg_out_if.source o_out
);
    import mavg_pkg::*;

    // Pipeline tracking: stage 1 = RAM read returns, stage 2 = sum held,
    // stage 3 = product held, then push into the result queue.
    t_stage           r_s1;
    t_stage           r_s2;
    t_stage           r_s3;
    logic             w_acc;
    logic             w_pop;
    logic [1:0]       w_inflight;
    logic [CNT_W:0]   w_used;
    logic [CNT_W-1:0] w_count;
    t_sample_arr      w_sample;
    t_sum_arr         w_sum;
    t_sample_arr      w_avg;
    t_result          w_res;
    t_result          w_head;

    // Take a word only when the queue has room for everything already in flight.
    assign w_inflight = 2'(r_s1.vld) + 2'(r_s2.vld) + 2'(r_s3.vld);
    assign w_used     = (CNT_W + 1)'(w_count) + (CNT_W + 1)'(w_inflight);
    assign i_in.ready = (w_used < (CNT_W + 1)'(FIFO_DEPTH));
    assign w_acc      = i_in.valid & i_in.ready;

    assign w_sample[0] = i_in.sample_a;
    assign w_sample[1] = i_in.sample_b;
    assign w_sample[2] = i_in.sample_c;
    assign w_sample[3] = i_in.sample_d;
    assign w_sample[4] = i_in.sample_e;

    // Advance the tag and valid alongside the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= '{vld: w_acc, tag: i_in.tag};
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // Ring RAMs and running sums; the sum updates as the old sample returns.
    mavg_bank u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_acc),
        .i_sample (w_sample),
        .i_upd    (r_s1.vld),
        .o_sum    (w_sum)
    );

    // Constant divide per channel.
    mavg_scale u_scale (
        .i_clk (i_clk),
        .i_sum (w_sum),
        .o_avg (w_avg)
    );

    assign w_res.tag_out = r_s3.tag;
    assign w_res.avg_a   = w_avg[0];
    assign w_res.avg_b   = w_avg[1];
    assign w_res.avg_c   = w_avg[2];
    assign w_res.avg_d   = w_avg[3];
    assign w_res.avg_e   = w_avg[4];

    // Hold finished words until the sink takes them.
    assign w_pop = o_out.valid & o_out.ready;

    mavg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3.vld),
        .i_wdata (w_res),
        .i_pop   (w_pop),
        .o_rdata (w_head),
        .o_valid (o_out.valid),
        .o_count (w_count)
    );

    assign o_out.tag_out = w_head.tag_out;
    assign o_out.avg_a   = w_head.avg_a;
    assign o_out.avg_b   = w_head.avg_b;
    assign o_out.avg_c   = w_head.avg_c;
    assign o_out.avg_d   = w_head.avg_d;
    assign o_out.avg_e   = w_head.avg_e;
endmodule
